/* sv/deq_pkg.sv */
`default_nettype none

package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = 32 + $clog2(DEPTH);
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	typedef logic signed [31:0] entry_t;
	typedef logic [1:0] cell_op_t;

	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_LOAD = 2'd1;
	localparam cell_op_t CELL_SHR  = 2'd2;
	localparam cell_op_t CELL_SHL  = 2'd3;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_DEL_MAX    = 3'd2;
	localparam logic [2:0] KIND_AVG_FRONT  = 3'd3;
	localparam logic [2:0] KIND_READ       = 3'd4;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [4:0]         entry_count;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] divisor;
	} div_ctl_t;

endpackage

`default_nettype wire

/* sv/deque_with_delete_max_top.sv */
// Push, read and unused kinds: the response is valid in the cycle after the request is taken.
// Delete max: the scan reads one cell per cycle, then the row shifts once.
// Average: the entries are summed, then the serial divider forms the mean.
// One request is in work at a time; a new one is taken once the response register is free.
// Reset clears the entry count and control state; cell contents stay undefined until pushed.
`default_nettype none

module deque_with_delete_max_top import deq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic [IDX_W-1:0]        best_idx_q;
	entry_t                  best_val_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	entry_t                  cell_val [DEPTH];
	cell_op_t                cell_op  [DEPTH];
	entry_t                  load_val;
	logic [IDX_W-1:0]        rd_idx;
	entry_t                  rd_val;
	logic                    req_fire;
	logic                    full;
	logic                    empty;
	logic                    last;
	div_ctl_t                div_ctl;
	logic                    div_done;
	entry_t                  mean;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign full      = cnt_q == CNT_W'(DEPTH);
	assign empty     = cnt_q == '0;
	assign last      = idx_q == cnt_q - 1'b1;

	assign rd_idx   = (state_q == ST_IDLE) ? IDX_W'(req.position) : idx_q[IDX_W-1:0];
	assign rd_val   = cell_val[rd_idx];
	assign sum_next = sum_q + SUM_W'(rd_val);
	assign load_val = (state_q == ST_DIV) ? mean : req.value;

	assign div_ctl.start   = (state_q == ST_SUM) && last;
	assign div_ctl.divisor = cnt_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = CELL_HOLD;
			if (req_fire && !full && req.kind == KIND_PUSH_FRONT) begin
				cell_op[i] = (i == 0) ? CELL_LOAD : CELL_SHR;
			end else if (req_fire && !full && req.kind == KIND_PUSH_BACK) begin
				if (CNT_W'(i) == cnt_q) begin
					cell_op[i] = CELL_LOAD;
				end
			end else if (state_q == ST_SHIFT) begin
				if (IDX_W'(i) >= best_idx_q) begin
					cell_op[i] = CELL_SHL;
				end
			end else if (state_q == ST_DIV && div_done && i == 0) begin
				cell_op[i] = CELL_LOAD;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		deq_cell u_cell (
			.clk       (clk),
			.op        (cell_op[g]),
			.load_val  (load_val),
			.left_val  ((g == 0) ? load_val : cell_val[(g == 0) ? 0 : g - 1]),
			.right_val ((g == DEPTH - 1) ? cell_val[g] : cell_val[(g == DEPTH - 1) ? g : g + 1]),
			.val       (cell_val[g])
		);
	end

	deq_mean_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (sum_next),
		.done     (div_done),
		.quotient (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.kind) inside
							KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
								rsp_valid_q <= 1'b1;
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							KIND_DEL_MAX: begin
								if (empty) begin
									rsp_valid_q <= 1'b1;
								end else if (cnt_q == CNT_W'(1)) begin
									state_q <= ST_SHIFT;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_AVG_FRONT: begin
								if (empty) begin
									rsp_valid_q <= 1'b1;
								end else begin
									state_q <= ST_SUM;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					cnt_q       <= cnt_q - 1'b1;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SUM: begin
					if (last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the control above decides when they matter.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					idx_q      <= (req.kind == KIND_DEL_MAX) ? CNT_W'(1) : '0;
					best_idx_q <= '0;
					best_val_q <= cell_val[0];
					sum_q      <= '0;
					rsp_q.data <= '0;
					rsp_q.entry_count <= 5'(cnt_q);
					rsp_q.status      <= STATUS_DONE;
					case (req.kind) inside
						KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
							if (full) begin
								rsp_q.status <= STATUS_FULL;
							end else begin
								rsp_q.entry_count <= 5'(cnt_q + 1'b1);
							end
						end
						KIND_DEL_MAX, KIND_AVG_FRONT: begin
							if (empty) begin
								rsp_q.status <= STATUS_EMPTY;
							end
						end
						KIND_READ: begin
							if (32'(req.position) >= 32'(cnt_q)) begin
								rsp_q.status <= STATUS_RANGE;
							end else begin
								rsp_q.data <= rd_val;
							end
						end
						default: begin
							rsp_q.status <= STATUS_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// Strictly greater keeps the first maximum from the front.
				if (rd_val > best_val_q) begin
					best_val_q <= rd_val;
					best_idx_q <= idx_q[IDX_W-1:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_SHIFT: begin
				rsp_q.data        <= best_val_q;
				rsp_q.entry_count <= 5'(cnt_q - 1'b1);
			end
			ST_SUM: begin
				sum_q <= sum_next;
				idx_q <= idx_q + 1'b1;
			end
			ST_DIV: begin
				if (div_done) begin
					rsp_q.data        <= mean;
					rsp_q.entry_count <= 5'(cnt_q);
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_rsp_free_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV && div_done) || state_q == ST_SHIFT) |-> !rsp_valid_q)
		else $error("response register busy when a long request finishes");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !full && (req.kind == KIND_PUSH_FRONT || req.kind == KIND_PUSH_BACK))
		|=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("successful push did not raise the count");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |=> (cnt_q == $past(cnt_q) - 1'b1) && rsp_valid_q)
		else $error("delete max did not lower the count and respond");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the average request");

endmodule

`default_nettype wire

/* sv/deq_cell.sv */
`default_nettype none

module deq_cell import deq_pkg::*; (
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire entry_t   load_val,
	input  wire entry_t   left_val,
	input  wire entry_t   right_val,
	output entry_t        val
);

	entry_t val_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: val_q <= load_val;
			CELL_SHR:  val_q <= left_val;
			CELL_SHL:  val_q <= right_val;
			default:   val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

/* sv/deq_mean_div.sv */
`default_nettype none

module deq_mean_div import deq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire div_ctl_t                ctl,
	input  wire logic signed [SUM_W-1:0] dividend,
	output logic                         done,
	output entry_t                       quotient
);

	logic [DIV_CNT_W-1:0] step_q;
	logic                 done_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic                 neg_q;
	logic [CNT_W:0]       trial;
	logic                 fits;
	logic [31:0]          mag;

	// Restoring division on magnitudes, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				step_q <= DIV_CNT_W'(SUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			rem_q <= '0;
			div_q <= ctl.divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign mag      = quo_q[31:0];
	assign quotient = neg_q ? -mag : mag;
	assign done     = done_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import deq_pkg::*;

	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam entry_t MAX_ENTRY = 32'sh7FFF_FFFF;
	localparam entry_t MIN_ENTRY = 32'sh8000_0000;
	localparam int ITEMS_PER_PHASE = 425;
	// Longest request is the average; the drain wait covers four of them at full depth.
	localparam int DRAIN_CYCLES = 4 * (DEPTH + SUM_W + 2);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Shadow copy of the deque, advanced at every accepted request.
	entry_t           shadow_cells [DEPTH];
	logic [IDX_W-1:0] shadow_front;
	logic [CNT_W-1:0] shadow_count;
	entry_t           last_pushed;

	rsp_t pending_rsps [$];
	rsp_t expected_rsp;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int requests_sent;
	int responses_seen;
	int kind_hits [8];
	int status_hits [4];

	deque_with_delete_max_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d responses still pending", pending_rsps.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int slot_of(int offset);
		return (int'(shadow_front) + offset) % DEPTH;
	endfunction

	// Applies one request to the shadow deque and returns the response it must produce.
	function automatic rsp_t deque_response(req_t r);
		rsp_t   o;
		int     best;
		int     i;
		longint total;
		o = '0;
		o.status = STATUS_DONE;
		case (r.kind)
			KIND_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
					shadow_cells[shadow_front] = r.value;
					shadow_count++;
					last_pushed = r.value;
				end
			end
			KIND_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					shadow_cells[slot_of(int'(shadow_count))] = r.value;
					shadow_count++;
					last_pushed = r.value;
				end
			end
			KIND_DEL_MAX: begin
				if (shadow_count == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					best = 0;
					for (i = 1; i < int'(shadow_count); i++) begin
						if (shadow_cells[slot_of(i)] > shadow_cells[slot_of(best)])
							best = i;
					end
					o.data = shadow_cells[slot_of(best)];
					for (i = best; i + 1 < int'(shadow_count); i++)
						shadow_cells[slot_of(i)] = shadow_cells[slot_of(i + 1)];
					shadow_count--;
				end
			end
			KIND_AVG_FRONT: begin
				if (shadow_count == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					total = 0;
					for (i = 0; i < int'(shadow_count); i++)
						total += longint'(shadow_cells[slot_of(i)]);
					// Signed longint division truncates toward zero.
					o.data = entry_t'(total / longint'(shadow_count));
					shadow_cells[shadow_front] = o.data;
				end
			end
			KIND_READ: begin
				if (r.position >= shadow_count)
					o.status = STATUS_RANGE;
				else
					o.data = shadow_cells[slot_of(int'(r.position))];
			end
			default: begin
			end
		endcase
		o.entry_count = 5'(shadow_count);
		kind_hits[r.kind]++;
		status_hits[o.status]++;
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: response %0d %s mismatch: expected %0h, got %0h",
				$realtime, responses_seen, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("unrequested", '0, rsp.data);
			end else begin
				expected_rsp = pending_rsps.pop_front();
				if (rsp.data !== expected_rsp.data)
					report_mismatch("data", expected_rsp.data, rsp.data);
				if (rsp.entry_count !== expected_rsp.entry_count)
					report_mismatch("entry_count", 32'(expected_rsp.entry_count),
						32'(rsp.entry_count));
				if (rsp.status !== expected_rsp.status)
					report_mismatch("status", 32'(expected_rsp.status), 32'(rsp.status));
			end
			responses_seen++;
		end
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic send_request(input req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_rsps.push_back(deque_response(item));
		requests_sent++;
	endtask

	task automatic issue(logic [2:0] kind, entry_t value, logic [3:0] position);
		req_t r;
		r.kind = kind;
		r.value = value;
		r.position = position;
		send_request(r);
	endtask

	function automatic entry_t random_value();
		case ($urandom_range(0, 9))
			0: return MAX_ENTRY;
			1: return MIN_ENTRY;
			2: return last_pushed;
			3: return entry_t'(int'($urandom_range(0, 20)) - 10);
			default: return entry_t'($urandom);
		endcase
	endfunction

	function automatic req_t random_request(bit filling);
		req_t r;
		int   pick;
		r.value = random_value();
		if (shadow_count != 0 && $urandom_range(0, 3) != 0)
			r.position = 4'($urandom_range(0, int'(shadow_count) - 1));
		else
			r.position = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < (filling ? 25 : 12))
			r.kind = KIND_PUSH_FRONT;
		else if (pick < (filling ? 50 : 24))
			r.kind = KIND_PUSH_BACK;
		else if (pick < (filling ? 62 : 60))
			r.kind = KIND_DEL_MAX;
		else if (pick < (filling ? 72 : 70))
			r.kind = KIND_AVG_FRONT;
		else if (pick < 95)
			r.kind = KIND_READ;
		else
			r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		return r;
	endfunction

	task automatic test_empty_queue();
		issue(KIND_DEL_MAX, MAX_ENTRY, '0);
		issue(KIND_AVG_FRONT, MIN_ENTRY, '1);
		issue(KIND_READ, '0, '0);
		issue(KIND_READ, '1, '1);
	endtask

	task automatic test_spare_kinds();
		for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
			issue(3'(k), entry_t'($urandom), 4'($urandom_range(0, 15)));
	endtask

	// Mean of -3, 0 and -2 must round toward zero, giving -1 and not -2.
	task automatic test_negative_mean();
		issue(KIND_PUSH_BACK, -32'sd3, '0);
		issue(KIND_PUSH_BACK, 32'sd0, '0);
		issue(KIND_PUSH_FRONT, -32'sd2, '0);
		issue(KIND_AVG_FRONT, '0, '0);
		issue(KIND_DEL_MAX, '0, '0);
		issue(KIND_READ, '0, 4'd1);
		issue(KIND_READ, '0, 4'd2);
	endtask

	// Fill with extremes, so the sum needs the full width and delete-max sees many ties.
	task automatic test_full_queue();
		bit at_front;
		at_front = 1'b1;
		issue(KIND_PUSH_BACK, MIN_ENTRY, '0);
		while (shadow_count < DEPTH) begin
			issue(at_front ? KIND_PUSH_FRONT : KIND_PUSH_BACK, MAX_ENTRY, '0);
			at_front = !at_front;
		end
		issue(KIND_PUSH_FRONT, MIN_ENTRY, '0);
		issue(KIND_PUSH_BACK, MAX_ENTRY, '0);
		issue(KIND_AVG_FRONT, '0, '0);
		issue(KIND_READ, '0, 4'(DEPTH - 1));
		issue(KIND_DEL_MAX, '0, '0);
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct);
		bit filling;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		filling = $urandom_range(0, 1);
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			// Alternate between growing and shrinking so every fill level is visited.
			if ($urandom_range(0, 29) == 0)
				filling = !filling;
			send_request(random_request(filling));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		shadow_front = '0;
		shadow_count = '0;
		last_pushed = '0;
		foreach (shadow_cells[i])
			shadow_cells[i] = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		requests_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_spare_kinds();
		test_negative_mean();
		test_full_queue();
		test_random_traffic(0, 0);
		test_random_traffic(83, 0);
		test_random_traffic(0, 83);
		test_random_traffic(27, 27);

		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d push front, %0d push back, %0d delete max,",
			requests_sent, kind_hits[KIND_PUSH_FRONT], kind_hits[KIND_PUSH_BACK],
			kind_hits[KIND_DEL_MAX]);
		$display("  %0d average, %0d read, %0d spare kind",
			kind_hits[KIND_AVG_FRONT], kind_hits[KIND_READ],
			requests_sent - kind_hits[KIND_PUSH_FRONT] - kind_hits[KIND_PUSH_BACK]
			- kind_hits[KIND_DEL_MAX] - kind_hits[KIND_AVG_FRONT] - kind_hits[KIND_READ]);
		$display("Responses checked %0d (%0d full, %0d empty, %0d out of range), %0d mismatches",
			responses_seen, status_hits[STATUS_FULL], status_hits[STATUS_EMPTY],
			status_hits[STATUS_RANGE], mismatch_count);
		if (mismatch_count == 0 && pending_rsps.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
sv/deq_pkg.sv
sv/deq_cell.sv
sv/deq_mean_div.sv
sv/deque_with_delete_max_top.sv
tb/testbench.sv
